// File: src/llex_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linear-program text lexer.
// Depends on nothing; every other file of the block imports it.
package llex_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_COUNT_BITS = 3;

   localparam logic [7:0] CH_LT = 8'h3C;
   localparam logic [7:0] CH_GT = 8'h3E;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_EQ = 8'h3D;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;

   localparam logic [6:0] LENGTH_MAX = 7'd127;

   typedef enum logic [2:0] {
      MODE_START = 3'd0,
      MODE_NAME = 3'd1,
      MODE_INT = 3'd2,
      MODE_FRAC = 3'd3,
      MODE_FRAC_OPEN = 3'd4,
      MODE_LT = 3'd5,
      MODE_GT = 3'd6,
      MODE_COMMENT = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      KIND_NUM = 4'd0,
      KIND_NAME = 4'd1,
      KIND_MUL = 4'd2,
      KIND_DIV = 4'd3,
      KIND_PLUS = 4'd4,
      KIND_MINUS = 4'd5,
      KIND_NEWLINE = 4'd6,
      KIND_END = 4'd7,
      KIND_LE = 4'd8,
      KIND_GE = 4'd9,
      KIND_EQ = 4'd10,
      KIND_LPAREN = 4'd11,
      KIND_RPAREN = 4'd12,
      KIND_ERROR = 4'd13
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0] start;
      logic [6:0] length;
      logic last;
   } token_type;

   typedef struct packed {
      logic valid0;
      logic valid1;
      token_type tok0;
      token_type tok1;
   } token_pair_type;

   typedef struct packed {
      mode_type mode;
      logic opens;
      logic emits;
      token_kind_type kind;
   } start_step_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {[8'h30:8'h39]});
   endfunction

   function automatic logic is_mark(input logic [7:0] c);
      return (c inside {CH_DOT, CH_COMMA});
   endfunction

   // What a byte does when the lexer is in its start state.
   function automatic start_step_type start_step(input logic [7:0] c);
      start_step_type r;
      r.mode = MODE_START;
      r.opens = 1'b0;
      r.emits = 1'b0;
      r.kind = KIND_ERROR;
      if (is_letter(c)) begin
         r.mode = MODE_NAME;
         r.opens = 1'b1;
      end else if (is_digit(c)) begin
         r.mode = MODE_INT;
         r.opens = 1'b1;
      end else begin
         case (c)
            CH_LT: begin
               r.mode = MODE_LT;
               r.opens = 1'b1;
            end
            CH_GT: begin
               r.mode = MODE_GT;
               r.opens = 1'b1;
            end
            CH_HASH: r.mode = MODE_COMMENT;
            CH_EQ: begin
               r.emits = 1'b1;
               r.kind = KIND_EQ;
            end
            CH_PLUS: begin
               r.emits = 1'b1;
               r.kind = KIND_PLUS;
            end
            CH_MINUS: begin
               r.emits = 1'b1;
               r.kind = KIND_MINUS;
            end
            CH_STAR: begin
               r.emits = 1'b1;
               r.kind = KIND_MUL;
            end
            CH_SLASH: begin
               r.emits = 1'b1;
               r.kind = KIND_DIV;
            end
            CH_LPAREN: begin
               r.emits = 1'b1;
               r.kind = KIND_LPAREN;
            end
            CH_RPAREN: begin
               r.emits = 1'b1;
               r.kind = KIND_RPAREN;
            end
            CH_NEWLINE: begin
               r.emits = 1'b1;
               r.kind = KIND_NEWLINE;
            end
            default: r.emits = 1'b0;
         endcase
      end
      return r;
   endfunction

endpackage

// File: src/linear_program_text_lexer.sv
`timescale 1ns / 1ps
// Top level of the linear-program text lexer: front end, token queue and
// output stage. Depends on llex_pkg, llex_front, llex_queue and llex_back.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    input_byte, end_of_input
//   rsp_     out        rsp_valid/rsp_ready    token_kind, token_start,
//                                              token_length, last_result
//
// One byte is taken per cycle while the token queue has room for two tokens.
// A token goes from the front end into the token queue and from there into
// the output register that drives rsp_.
// A byte that yields two tokens has them offered on rsp_ one after the other by
// the single output register. Reset clears the lexer state, byte position, queue and output valid.
// A stall on rsp_ fills the queue until it lacks room for two tokens, which drops req_ready.
module linear_program_text_lexer #(
   parameter int MAX_TOKEN_LEN = 128,
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_input_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [6:0]  rsp_token_length,
   output logic        rsp_last_result
);
   import llex_pkg::*;

   token_pair_type pair;
   token_type head, out_tok;
   logic room, head_valid, pop, accept;

   assign req_ready = room;
   assign accept = req_valid && room;

   llex_front #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .input_byte(req_input_byte),
      .end_of_input(req_end_of_input),
      .pair(pair)
   );

   llex_queue u_queue (
      .clock(clock),
      .reset(reset),
      .pair(pair),
      .pop(pop),
      .room(room),
      .head_valid(head_valid),
      .head(head)
   );

   llex_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head(head),
      .pop(pop),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_tok(out_tok)
   );

   assign rsp_token_kind = out_tok.kind;
   assign rsp_token_start = out_tok.start;
   assign rsp_token_length = out_tok.length;
   assign rsp_last_result = out_tok.last;

endmodule

// File: src/llex_front.sv
`timescale 1ns / 1ps
// Front end of the lexer: the character state machine that turns one byte
// into up to two tokens. Depends on llex_pkg.
module llex_front #(
   parameter int MAX_TOKEN_LEN = 128,
   parameter int POSITION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              input_byte,
   input  logic                    end_of_input,
   output llex_pkg::token_pair_type pair
);
   import llex_pkg::*;

   localparam int LenLimit = (MAX_TOKEN_LEN - 1 < 127) ? MAX_TOKEN_LEN - 1 : 127;

   mode_type mode_ff, mode_in;
   logic [6:0] len_ff, len_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   logic [31:0] pos_ext, start_ext;
   logic [15:0] pos_lo, start_lo;
   logic [7:0] len_p1;
   logic [6:0] len_p1_sat;
   logic at_limit, reproc;
   start_step_type sres;
   logic a_v, b_v;
   token_type tok_a, tok_b;

   assign pos_ext = 32'(pos_ff);
   assign start_ext = 32'(start_ff);
   assign pos_lo = pos_ext[15:0];
   assign start_lo = start_ext[15:0];
   assign len_p1 = {1'b0, len_ff} + 8'd1;
   assign len_p1_sat = len_p1[7] ? LENGTH_MAX : len_p1[6:0];
   assign at_limit = (len_ff >= 7'(LenLimit));
   assign sres = start_step(input_byte);

   always_comb begin
      mode_in = mode_ff;
      len_in = len_ff;
      start_in = start_ff;
      pos_in = pos_ff;
      reproc = 1'b0;
      a_v = 1'b0;
      b_v = 1'b0;
      tok_a = '{kind: KIND_ERROR, start: start_lo, length: len_ff, last: 1'b0};
      tok_b = '{kind: KIND_END, start: pos_lo, length: 7'd0, last: 1'b1};
      if (end_of_input) begin
         case (mode_ff)
            MODE_NAME: begin
               a_v = 1'b1;
               tok_a.kind = KIND_NAME;
            end
            MODE_INT, MODE_FRAC: begin
               a_v = 1'b1;
               tok_a.kind = KIND_NUM;
            end
            MODE_FRAC_OPEN, MODE_LT, MODE_GT: a_v = 1'b1;
            default: a_v = 1'b0;
         endcase
         b_v = 1'b1;
         mode_in = MODE_START;
         len_in = 7'd0;
      end else begin
         pos_in = pos_ff + POSITION_BITS'(1);
         case (mode_ff)
            MODE_START: begin
               mode_in = sres.mode;
               if (sres.opens) begin
                  start_in = pos_ff;
                  len_in = 7'd1;
               end
               a_v = sres.emits;
               tok_a = '{kind: sres.kind, start: pos_lo, length: 7'd1, last: 1'b0};
            end
            MODE_NAME, MODE_INT, MODE_FRAC, MODE_FRAC_OPEN: begin
               if (is_digit(input_byte) || (mode_ff == MODE_NAME && is_letter(input_byte))
                   || (mode_ff == MODE_INT && is_mark(input_byte))) begin
                  if (at_limit) begin
                     a_v = 1'b1;
                     mode_in = MODE_START;
                     len_in = 7'd0;
                  end else begin
                     len_in = len_p1[6:0];
                     if (mode_ff == MODE_INT && is_mark(input_byte)) begin
                        mode_in = MODE_FRAC_OPEN;
                     end else if (mode_ff == MODE_FRAC_OPEN) begin
                        mode_in = MODE_FRAC;
                     end
                  end
               end else if (mode_ff == MODE_FRAC_OPEN
                            || (mode_ff == MODE_FRAC && is_mark(input_byte))) begin
                  a_v = 1'b1;
                  tok_a.length = len_p1_sat;
                  mode_in = MODE_START;
                  len_in = 7'd0;
               end else begin
                  a_v = 1'b1;
                  tok_a.kind = (mode_ff == MODE_NAME) ? KIND_NAME : KIND_NUM;
                  mode_in = MODE_START;
                  len_in = 7'd0;
                  reproc = 1'b1;
               end
            end
            MODE_LT, MODE_GT: begin
               a_v = 1'b1;
               mode_in = MODE_START;
               len_in = 7'd0;
               if (input_byte == CH_EQ) begin
                  tok_a.kind = (mode_ff == MODE_LT) ? KIND_LE : KIND_GE;
                  tok_a.length = 7'd2;
               end else begin
                  tok_a.length = 7'd1;
                  reproc = 1'b1;
               end
            end
            default: begin
               if (input_byte == CH_NEWLINE) begin
                  mode_in = MODE_START;
                  reproc = 1'b1;
               end
            end
         endcase
         if (reproc) begin
            mode_in = sres.mode;
            if (sres.opens) begin
               start_in = pos_ff;
               len_in = 7'd1;
            end
            b_v = sres.emits;
            tok_b = '{kind: sres.kind, start: pos_lo, length: 7'd1, last: 1'b1};
         end
      end
   end

   always_comb begin
      pair.valid0 = a_v | b_v;
      pair.valid1 = a_v & b_v;
      pair.tok0 = a_v ? tok_a : tok_b;
      pair.tok0.last = ~(a_v & b_v);
      pair.tok1 = tok_b;
      pair.tok1.last = 1'b1;
      if (!accept) begin
         pair.valid0 = 1'b0;
         pair.valid1 = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
         len_ff <= 7'd0;
         start_ff <= '0;
         pos_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         len_ff <= len_in;
         start_ff <= start_in;
         pos_ff <= pos_in;
      end
   end

endmodule

// File: src/llex_queue.sv
`timescale 1ns / 1ps
// Short token queue between the lexer front end and the output stage;
// takes up to two tokens a cycle and gives one per pop of the output stage. Depends on llex_pkg.
module llex_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  llex_pkg::token_pair_type pair,
   input  logic                     pop,
   output logic                     room,
   output logic                     head_valid,
   output llex_pkg::token_type      head
);
   import llex_pkg::*;

   token_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_COUNT_BITS-1:0] push_n;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;

   assign push_n = QUEUE_COUNT_BITS'(pair.valid0) + QUEUE_COUNT_BITS'(pair.valid1);
   assign wr_ptr_next = wr_ptr_ff + QUEUE_PTR_BITS'(1);
   assign wr_ptr_in = wr_ptr_ff + push_n[QUEUE_PTR_BITS-1:0];
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
   assign count_in = count_ff + push_n - QUEUE_COUNT_BITS'(pop);
   assign room = (count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH - 2));
   assign head_valid = (count_ff != '0);
   assign head = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (pair.valid0) begin
         entry_ff[wr_ptr_ff] <= pair.tok0;
      end
      if (pair.valid1) begin
         entry_ff[wr_ptr_next] <= pair.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: src/llex_back.sv
`timescale 1ns / 1ps
// Output stage of the lexer: a register that holds the token on offer
// and refills from the token queue. Depends on llex_pkg.
module llex_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  llex_pkg::token_type head,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output llex_pkg::token_type out_tok
);
   import llex_pkg::*;

   logic valid_ff, valid_in;
   token_type tok_ff;

   assign pop = head_valid && (!valid_ff || out_ready);
   assign valid_in = pop || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_tok = tok_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         tok_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule
